@@ src/mf3_pkg.sv @@
// Shared types and constants of the 3x3 median filter.
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int SIZE_W     = 11;
  localparam int COORD_W    = 10;
  localparam int PIX_W      = 8;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int SIZE_RESET = 512;
  // Queue depth must stay a power of two: the pointers wrap on their own.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t pixel;
    logic frame_start;
  } in_t;

  typedef struct packed {
    pix_t                median;
    logic [COORD_W-1:0]  center_row;
    logic [COORD_W-1:0]  center_col;
    logic                last_of_frame;
  } out_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } pos_t;

  // px[3*k + j]: column k (0 oldest), row j (0 top)
  typedef struct packed {
    pix_t [8:0] px;
    pos_t       pos;
  } win_t;

endpackage

@@ src/mf3_front.sv @@
// Front part: configuration, position counters, line stores and window.
module mf3_front import mf3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output win_t              push_data_o
);

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] hi);
    if (v < SIZE_W'(3)) return SIZE_W'(3);
    if (v > hi) return hi;
    return v;
  endfunction

  logic [SIZE_W-1:0]  width_q, height_q;
  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;

  logic               s1_valid_q, s1_emit_q, s1_last_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  pix_t               s1_pix_q;
  logic [COORD_W-1:0] s1_row_q, s1_col_q;

  logic               byp_q;
  pix_t               byp_up_q, byp_mid_q;
  pix_t               up_rd_q, mid_rd_q;
  pix_t               up_eff, mid_eff;
  pix_t               upper_mem [MAX_WIDTH];
  pix_t               middle_mem [MAX_WIDTH];
  pix_t [5:0]         win_q;

  logic               accept, s1_adv;
  logic [ADDR_W-1:0]  rd_addr;
  logic [SIZE_W-1:0]  pos_r, pos_c;
  logic               emit_d, last_d;

  // Configuration: store the clamped size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(SIZE_RESET);
      height_q <= SIZE_W'(SIZE_RESET);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IMAGE_WIDTH) begin
        width_q <= clamp_size(cfg_data_i, SIZE_W'(MAX_WIDTH));
      end else begin
        height_q <= clamp_size(cfg_data_i, SIZE_W'(MAX_HEIGHT));
      end
    end
  end

  assign s1_adv     = s1_valid_q && (!s1_emit_q || push_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // Position of the incoming item and the counters after it.
  always_comb begin
    logic [SIZE_W-1:0] c0, r0, r1, cn, rn;
    c0 = in_data_i.frame_start ? '0 : {1'b0, col_q};
    r0 = in_data_i.frame_start ? '0 : {1'b0, row_q};
    if (c0 >= width_q) begin
      pos_c = '0;
      r1    = r0 + SIZE_W'(1);
    end else begin
      pos_c = c0;
      r1    = r0;
    end
    pos_r = (r1 >= height_q) ? '0 : r1;
    cn    = pos_c + SIZE_W'(1);
    rn    = pos_r + SIZE_W'(1);
    if (cn >= width_q) begin
      col_d = '0;
      row_d = (rn >= height_q) ? '0 : rn[COORD_W-1:0];
    end else begin
      col_d = cn[COORD_W-1:0];
      row_d = pos_r[COORD_W-1:0];
    end
    emit_d  = (pos_r >= SIZE_W'(2)) && (pos_c >= SIZE_W'(2));
    last_d  = (pos_r == height_q - SIZE_W'(1)) && (pos_c == width_q - SIZE_W'(1));
    rd_addr = pos_c[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
        // The item ahead writes this column in the same cycle: forward it.
        byp_q      <= s1_adv && (s1_addr_q == rd_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= rd_addr;
      s1_pix_q  <= in_data_i.pixel;
      s1_emit_q <= emit_d;
      s1_last_q <= last_d;
      s1_row_q  <= pos_r[COORD_W-1:0] - COORD_W'(1);
      s1_col_q  <= pos_c[COORD_W-1:0] - COORD_W'(1);
      byp_up_q  <= mid_eff;
      byp_mid_q <= s1_pix_q;
    end
  end

  // Line stores: one read and one write per cycle.
  always_ff @(posedge clk_i) begin
    if (s1_adv) upper_mem[s1_addr_q] <= mid_eff;
    if (accept) up_rd_q <= upper_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) middle_mem[s1_addr_q] <= s1_pix_q;
    if (accept) mid_rd_q <= middle_mem[rd_addr];
  end

  assign up_eff  = byp_q ? byp_up_q  : up_rd_q;
  assign mid_eff = byp_q ? byp_mid_q : mid_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q[2:0] <= win_q[5:3];
      win_q[3]   <= up_eff;
      win_q[4]   <= mid_eff;
      win_q[5]   <= s1_pix_q;
    end
  end

  assign push_valid_o          = s1_valid_q && s1_emit_q;
  assign push_data_o.px[5:0]   = win_q;
  assign push_data_o.px[6]     = up_eff;
  assign push_data_o.px[7]     = mid_eff;
  assign push_data_o.px[8]     = s1_pix_q;
  assign push_data_o.pos.row   = s1_row_q;
  assign push_data_o.pos.col   = s1_col_q;
  assign push_data_o.pos.last  = s1_last_q;

endmodule

@@ src/mf3_fifo.sv @@
// Short queue of complete windows between front and back parts.
module mf3_fifo import mf3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  win_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output win_t pop_data_o
);

  win_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q;
  logic                  push, pop;

  assign push_ready_o = (count_q != (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      if (push && !pop) begin
        count_q <= count_q + (FIFO_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (FIFO_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ src/mf3_back.sv @@
// Back part: three-stage median network whose last stage is the output register.
module mf3_back import mf3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pop_valid_i,
  output logic pop_ready_o,
  input  win_t pop_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic       en;
  logic       b1_valid_q, b2_valid_q, out_valid_q;
  pix_t [2:0] lo_q, md_q, hi_q;
  pix_t       mx_lo_q, md_md_q, mn_hi_q;
  pos_t       b1_pos_q, b2_pos_q;
  out_t       out_q;

  // Stall the whole network while a result waits.
  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b1_valid_q  <= pop_valid_i;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // sort each column
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= min2(min2(pop_data_i.px[3*k], pop_data_i.px[3*k+1]),
                        pop_data_i.px[3*k+2]);
        md_q[k] <= med3(pop_data_i.px[3*k], pop_data_i.px[3*k+1],
                        pop_data_i.px[3*k+2]);
        hi_q[k] <= max2(max2(pop_data_i.px[3*k], pop_data_i.px[3*k+1]),
                        pop_data_i.px[3*k+2]);
      end
      b1_pos_q <= pop_data_i.pos;
      // max of lows, median of middles, min of highs
      mx_lo_q  <= max2(max2(lo_q[0], lo_q[1]), lo_q[2]);
      md_md_q  <= med3(md_q[0], md_q[1], md_q[2]);
      mn_hi_q  <= min2(min2(hi_q[0], hi_q[1]), hi_q[2]);
      b2_pos_q <= b1_pos_q;
      out_q.median        <= med3(mx_lo_q, md_md_q, mn_hi_q);
      out_q.center_row    <= b2_pos_q.row;
      out_q.center_col    <= b2_pos_q.col;
      out_q.last_of_frame <= b2_pos_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/median_filter_3x3.sv @@
// Each window passes the front stage register, the window queue and the network registers.
// One pixel per cycle if the queue has room; each line store reads and writes once per cycle.
// A stalled output fills a 4-entry window queue before the input side stops.
// Reset clears counters, window, pipeline valids and sets width and height to 512.
// Line stores are not cleared; rows 0 and 1 of each frame fill them before any use.
// Top level of the 3x3 median filter.
module median_filter_3x3 import mf3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o
);

  // front -> queue
  logic push_valid, push_ready;
  win_t push_data;
  // queue -> back
  logic pop_valid, pop_ready;
  win_t pop_data;

  // Track position, keep the two line stores and build the window;
  // hand on only windows that have an interior center.
  mf3_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple the two sides so each can stall on its own.
  mf3_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Sort columns, combine, take the middle; hold the result until taken.
  mf3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/mf3_checker.sv @@
// Port-level checks of the 3x3 median filter, bound to the top level.
module mf3_checker import mf3_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_border_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.center_row != '0 && out_data_o.center_col != '0)
    else $error("result centered on the first row or column");

  a_no_border_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.center_row != '1 && out_data_o.center_col != '1)
    else $error("result centered beyond the largest interior position");

  // The edge that sees reset low has cleared the output by the next edge.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

endmodule

bind median_filter_3x3 mf3_checker u_checker (.*);

@@ sim/median_filter_3x3_tb.sv @@
// Self-checking testbench of the 3x3 median filter: a directed frame table, then random phases.
module median_filter_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  // Margin that settle() waits after the last owed median, for the pipeline to drain.
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 14;

  // One row of the directed table. Where typed is set, res is the result that row must
  // give; every other row is checked against the window model below.
  typedef struct packed {
    pix_t pixel;
    logic frame_start;
    logic typed;
    out_t res;
  } dir_row_t;

  localparam dir_row_t DIRECTED [25] = '{
    // All-white 3x3 frame: the only interior position is (1,1) and its median is 255.
    '{8'd255, 1'b1, 1'b0, '0},
    '{8'd255, 1'b0, 1'b0, '0},
    '{8'd255, 1'b0, 1'b0, '0},
    '{8'd255, 1'b0, 1'b0, '0},
    '{8'd255, 1'b0, 1'b0, '0},
    '{8'd255, 1'b0, 1'b0, '0},
    '{8'd255, 1'b0, 1'b0, '0},
    '{8'd255, 1'b0, 1'b0, '0},
    '{8'd255, 1'b0, 1'b1, '{8'd255, 10'd1, 10'd1, 1'b1}},
    // All-black frame with no start flag: the counters must wrap to (0,0) on their own.
    '{8'd0, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b0, '0},
    '{8'd0, 1'b0, 1'b1, '{8'd0, 10'd1, 10'd1, 1'b1}},
    // Mixed values, then a start flag in the middle of the frame restarts at (0,0).
    '{8'd10,  1'b1, 1'b0, '0},
    '{8'd200, 1'b0, 1'b0, '0},
    '{8'd30,  1'b0, 1'b0, '0},
    '{8'd5,   1'b1, 1'b0, '0},
    '{8'd250, 1'b0, 1'b0, '0},
    '{8'd128, 1'b0, 1'b0, '0},
    '{8'd1,   1'b0, 1'b0, '0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [0:0]        cfg_idx_i;
  logic [SIZE_W-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  in_t               in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_t              out_data_o;

  // Window model: line stores, the 3x3 window, the raster position and the size registers.
  pix_t              upper_line  [MAX_WIDTH];
  pix_t              middle_line [MAX_WIDTH];
  pix_t              window_px   [9];
  int unsigned       row_pos;
  int unsigned       col_pos;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  // Medians still owed by the block, oldest first.
  out_t              pending_medians [$];

  int unsigned       err_cnt;
  int unsigned       cycle_cnt;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;

  median_filter_3x3 DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Saturate a size register to [3, hi].
  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v, input int unsigned hi);
    int unsigned val;
    val = 32'(v);
    if (val < 3) return 3;
    if (val > hi) return hi;
    return val;
  endfunction

  // The median is the value with at most four smaller entries and at least five
  // entries not larger than it.
  function automatic pix_t median_of_window();
    int unsigned lt;
    int unsigned eq;
    for (int i = 0; i < 9; i++) begin
      lt = 0;
      eq = 0;
      for (int j = 0; j < 9; j++) begin
        if (window_px[j] < window_px[i]) lt++;
        else if (window_px[j] == window_px[i]) eq++;
      end
      if (lt <= 4 && lt + eq >= 5) return window_px[i];
    end
    return window_px[4];
  endfunction

  // Advance the model by one accepted pixel; return 1 when it completes an interior window.
  function automatic bit filter_pixel(input in_t item, output out_t res);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    pix_t        up;
    pix_t        mid;
    bit          hit;
    w   = eff_size(width_reg, MAX_WIDTH);
    h   = eff_size(height_reg, MAX_HEIGHT);
    res = '0;
    hit = 1'b0;
    if (item.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    // A shrunken width pushes the position to the next row, a shrunken height to row 0.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r   = row_pos;
    c   = col_pos;
    up  = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = item.pixel;
    for (int k = 0; k < 6; k++) window_px[k] = window_px[k+3];
    window_px[6] = up;
    window_px[7] = mid;
    window_px[8] = item.pixel;
    if (r >= 2 && c >= 2) begin
      res.median        = median_of_window();
      res.center_row    = COORD_W'(r - 1);
      res.center_col    = COORD_W'(c - 1);
      res.last_of_frame = (r == h - 1) && (c == w - 1);
      hit = 1'b1;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return hit;
  endfunction

  // Mostly uniform values, some black/white extremes, some clustered values for ties.
  function automatic pix_t random_pixel();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    if (sel < 30) return pix_t'($urandom_range(135, 120));
    return pix_t'($urandom_range(255));
  endfunction

  // Offer one pixel item, idle first at random, and book its result once accepted.
  task automatic send_pixel(input in_t item, input bit typed, input out_t typed_res);
    out_t res;
    bit   hit;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    hit = filter_pixel(item, res);
    if (typed) pending_medians.push_back(typed_res);
    else if (hit) pending_medians.push_back(res);
  endtask

  // Drop valid, wait for every owed median, then let pixels with no result drain out.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both size registers on consecutive cycles; call only while the block is idle.
  task automatic write_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IMAGE_WIDTH;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_IMAGE_HEIGHT;
    cfg_data_i <= h;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  // Receiver: stall at random at the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result, field by field, with the oldest owed median.
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_medians.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("cycle %0d: unexpected result median %0d row %0d col %0d last %0b",
                   cycle_cnt, out_data_o.median, out_data_o.center_row,
                   out_data_o.center_col, out_data_o.last_of_frame);
      end else begin
        want = pending_medians.pop_front();
        if (out_data_o.median !== want.median || out_data_o.center_row !== want.center_row ||
            out_data_o.center_col !== want.center_col ||
            out_data_o.last_of_frame !== want.last_of_frame) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("cycle %0d: expected median %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                     cycle_cnt, want.median, want.center_row, want.center_col,
                     want.last_of_frame, out_data_o.median, out_data_o.center_row,
                     out_data_o.center_col, out_data_o.last_of_frame);
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("median_filter_3x3 regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    in_t               item;
    logic [SIZE_W-1:0] w_wr;
    logic [SIZE_W-1:0] h_wr;
    int unsigned       count;
    int unsigned       noise_pct;
    bit                full_frame;
    bit                restart;
    int                p;
    int unsigned       n;

    // Hold every input at a known value through reset.
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_IMAGE_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    send_idle_pct = 31;
    recv_idle_pct = 56;

    // Model state after reset.
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) window_px[i] = '0;
    row_pos    = 0;
    col_pos    = 0;
    width_reg  = SIZE_W'(SIZE_RESET);
    height_reg = SIZE_W'(SIZE_RESET);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the smallest frame.
    write_sizes(11'd3, 11'd3);
    foreach (DIRECTED[i]) begin
      item.pixel       = DIRECTED[i].pixel;
      item.frame_start = DIRECTED[i].frame_start;
      send_pixel(item, DIRECTED[i].typed, DIRECTED[i].res);
    end

    // Random phases: sender idles 31% / receiver 56%, then swapped, then no idling.
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 5) begin
        send_idle_pct = 31;
        recv_idle_pct = 56;
      end else if (p < 10) begin
        send_idle_pct = 56;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      full_frame = 1'b0;
      noise_pct  = 3;
      case (p)
        4: begin
          // Widest row: an over-range width saturates to 1024, a zero height to 3.
          // The phase ends inside row 0, so it yields no results.
          w_wr       = 11'd2047;
          h_wr       = 11'd0;
          count      = 50;
          full_frame = 1'b1;
          noise_pct  = 0;
        end
        9: begin
          // Tall frame: width 1 saturates to 3, an over-range height to 1024;
          // rows run well past 3 without wrapping.
          w_wr       = 11'd1;
          h_wr       = 11'd2047;
          count      = 50;
          full_frame = 1'b1;
          noise_pct  = 0;
        end
        6: begin
          // Exact upper height bound, left mid-frame for the next phase to shrink.
          w_wr  = SIZE_W'($urandom_range(12, 3));
          h_wr  = SIZE_W'(MAX_HEIGHT);
          count = 60;
        end
        default: begin
          w_wr  = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(2))
                                           : SIZE_W'($urandom_range(12, 3));
          h_wr  = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(2))
                                           : SIZE_W'($urandom_range(8, 3));
          count = $urandom_range(70, 40);
        end
      endcase

      settle();
      // A wider row would read line store columns that the current frame never filled:
      // restart the frame so rows 0 and 1 fill them first. Shrinks need no restart.
      restart = full_frame ||
                (eff_size(w_wr, MAX_WIDTH) > eff_size(width_reg, MAX_WIDTH));
      write_sizes(w_wr, h_wr);

      for (n = 0; n < count; n++) begin
        item.pixel       = random_pixel();
        // Start flags: forced where needed, often at a natural frame boundary,
        // and now and then in mid-frame as noise.
        item.frame_start = (n == 0 && restart) ||
                           ($urandom_range(99) < noise_pct) ||
                           (noise_pct != 0 && row_pos == 0 && col_pos == 0 &&
                            $urandom_range(1) == 1);
        send_pixel(item, 1'b0, '0);
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("median_filter_3x3 regression: pass");
    end else begin
      $display("median_filter_3x3 regression: fail");
    end
    $finish;
  end

endmodule

@@ median_filter_3x3.f @@
src/mf3_pkg.sv
src/mf3_front.sv
src/mf3_fifo.sv
src/mf3_back.sv
src/median_filter_3x3.sv
src/mf3_checker.sv
sim/median_filter_3x3_tb.sv
